>>> rtl/core/chbd_pkg.sv
// shared types and constants of the canonical huffman bit decoder
package chbd_pkg;

    localparam int MAX_CODE_LENGTH = 16;
    localparam int MAX_SYMBOLS     = 256;
    localparam int LEVELS          = 16;

    localparam int OP_W       = 3;
    localparam int LEVEL_W    = 4;
    localparam int COUNT_W    = 8;
    localparam int SYM_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int ADDR_W     = 8;
    localparam int LOADED_W   = 9;
    localparam int CODE_W     = 16;
    localparam int LEN_W      = 5;
    localparam int FIRST_W    = 17;
    localparam int OFFSET_W   = 9;
    localparam int BCODE_W    = 19;
    localparam int BOFF_W     = 12;
    localparam int STORE_DEPTH = 256;

    localparam logic [BCODE_W-1:0] BCODE_MAX = BCODE_W'(18'h3FFFF);

    typedef enum logic [OP_W-1:0] {
        OP_START     = 3'd0,
        OP_SET_COUNT = 3'd1,
        OP_APPEND    = 3'd2,
        OP_FINISH    = 3'd3,
        OP_DECODE    = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_CODE   = 2'd1,
        ST_BAD_TABLE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUILD,
        S_RESP
    } t_state;

    typedef struct packed {
        logic take;
        logic build_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_finish;
        logic build_last;
        logic out_free;
    } t_dp_stat;

endpackage

>>> rtl/core/chbd_in_if.sv
// input word channel of the huffman decoder
interface chbd_in_if;
    logic                          valid;
    logic                          ready;
    logic [chbd_pkg::OP_W-1:0]     op;
    logic [chbd_pkg::LEVEL_W-1:0]  level;
    logic [chbd_pkg::COUNT_W-1:0]  code_count;
    logic [chbd_pkg::SYM_W-1:0]    symbol_in;
    logic                          bit_in;

    modport source (output valid, output op, output level, output code_count,
                    output symbol_in, output bit_in, input ready);
    modport sink (input valid, input op, input level, input code_count,
                  input symbol_in, input bit_in, output ready);
endinterface

>>> rtl/core/chbd_out_if.sv
// result word channel of the huffman decoder
interface chbd_out_if;
    logic                          valid;
    logic                          ready;
    logic [chbd_pkg::SYM_W-1:0]    symbol_out;
    logic                          symbol_done;
    logic [chbd_pkg::STATUS_W-1:0] status;

    modport source (output valid, output symbol_out, output symbol_done,
                    output status, input ready);
    modport sink (input valid, input symbol_out, input symbol_done,
                  input status, output ready);
endinterface

>>> rtl/core/chbd_ctrl.sv
// controller state machine of the huffman decoder
module chbd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  chbd_pkg::t_dp_stat i_stat,
    output chbd_pkg::t_dp_cmd  o_cmd
);
    import chbd_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   take;

    assign take = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_state = i_stat.is_finish ? S_BUILD : S_RESP;
                end
            end
            S_BUILD: begin
                if (i_stat.build_last) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    if (take) begin
                        n_state = i_stat.is_finish ? S_BUILD : S_RESP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd.build_step = 1'b0;
        o_cmd.load_out   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_BUILD: begin
                o_cmd.build_step = 1'b1;
            end
            S_RESP: begin
                o_in_ready     = i_stat.out_free;
                o_cmd.load_out = i_stat.out_free;
            end
            default: ;
        endcase
        o_cmd.take = take;
    end

    a_build_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BUILD) && !i_stat.build_last |=> r_state == S_BUILD)
        else $error("build walk left early");

    a_no_take_in_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_BUILD |-> !o_in_ready)
        else $error("input taken during build walk");

    a_state_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) || (r_state == S_BUILD) || (r_state == S_RESP))
        else $error("illegal controller state");

endmodule

>>> rtl/core/chbd_dp.sv
// table storage, canonical build and bit decode datapath
module chbd_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  chbd_pkg::t_dp_cmd             i_cmd,
    output chbd_pkg::t_dp_stat            o_stat,
    input  logic [chbd_pkg::OP_W-1:0]     i_op,
    input  logic [chbd_pkg::LEVEL_W-1:0]  i_level,
    input  logic [chbd_pkg::COUNT_W-1:0]  i_code_count,
    input  logic [chbd_pkg::SYM_W-1:0]    i_symbol_in,
    input  logic                          i_bit_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [chbd_pkg::SYM_W-1:0]    o_symbol_out,
    output logic                          o_symbol_done,
    output logic [chbd_pkg::STATUS_W-1:0] o_status
);
    import chbd_pkg::*;

    // table
    logic [COUNT_W-1:0]  r_level_counts [LEVELS];
    logic [FIRST_W-1:0]  r_first_codes [LEVELS];
    logic [OFFSET_W-1:0] r_symbol_offsets [LEVELS];
    logic [SYM_W-1:0]    mem_store [STORE_DEPTH];
    logic [LOADED_W-1:0] r_symbols_loaded;
    logic                r_symbols_overflow;
    logic                r_table_valid;
    logic [LEN_W-1:0]    r_deepest_length;
    logic [CODE_W-1:0]   r_last_code;

    // decode position
    logic [CODE_W-1:0]   r_prefix_code;
    logic [LEN_W-1:0]    r_prefix_length;

    // build walk
    logic [LEVEL_W-1:0]  r_build_idx;
    logic [BCODE_W-1:0]  r_build_code;
    logic [BOFF_W-1:0]   r_build_offset;
    logic                r_build_good;

    // pending and output words
    logic [SYM_W-1:0]    r_rd_data;
    logic                r_pend_done;
    t_status             r_pend_status;
    logic                n_pend_done;
    t_status             n_pend_status;
    logic                r_out_valid;
    logic [SYM_W-1:0]    r_out_sym;
    logic                r_out_done;
    t_status             r_out_status;

    logic [LEVEL_W-1:0]  rd_idx;
    logic [COUNT_W-1:0]  rd_count;

    logic [LEN_W-1:0]    dec_len;
    logic [CODE_W-1:0]   dec_code;
    logic [FIRST_W-1:0]  dec_first;
    logic [FIRST_W-1:0]  dec_diff;
    logic                dec_hit;
    logic [ADDR_W-1:0]   dec_addr;
    logic [LEN_W-1:0]    dec_shift;
    logic [CODE_W-1:0]   dec_limit;
    logic                dec_extend;

    logic [LEN_W-1:0]    b_len;
    logic [BCODE_W-1:0]  b_sum;
    logic [BCODE_W-1:0]  b_limit;
    logic [BCODE_W:0]    b_dbl;
    logic [BCODE_W-1:0]  b_next;
    logic [BOFF_W-1:0]   b_off_next;
    logic                b_good;
    logic                b_final;
    logic                store_room;

    // one read port on the count table, shared by build and decode
    assign rd_idx   = i_cmd.build_step ? r_build_idx : r_prefix_length[LEVEL_W-1:0];
    assign rd_count = r_level_counts[rd_idx];

    always_comb begin
        dec_len    = r_prefix_length + LEN_W'(1);
        dec_code   = {r_prefix_code[CODE_W-2:0], i_bit_in};
        dec_first  = r_first_codes[rd_idx];
        dec_diff   = {1'b0, dec_code} - dec_first;
        dec_hit    = (dec_len <= LEN_W'(LEVELS)) && ({1'b0, dec_code} >= dec_first)
                     && (dec_diff < FIRST_W'(rd_count));
        dec_addr   = r_symbol_offsets[rd_idx][ADDR_W-1:0] + dec_diff[ADDR_W-1:0];
        dec_shift  = r_deepest_length - dec_len;
        dec_limit  = r_last_code >> dec_shift;
        dec_extend = (dec_len < r_deepest_length) && (dec_len < LEN_W'(LEVELS))
                     && (dec_code <= dec_limit);
    end

    always_comb begin
        b_len      = {1'b0, r_build_idx} + LEN_W'(1);
        b_sum      = (b_len <= LEN_W'(MAX_CODE_LENGTH))
                     ? r_build_code + BCODE_W'(rd_count) : r_build_code;
        b_limit    = BCODE_W'(1) << b_len;
        b_dbl      = {b_sum, 1'b0};
        b_next     = (b_dbl > {1'b0, BCODE_MAX}) ? BCODE_MAX : b_dbl[BCODE_W-1:0];
        b_off_next = r_build_offset + BOFF_W'(rd_count);
        b_good     = r_build_good && !(b_sum > b_limit);
        b_final    = b_good && (b_off_next == BOFF_W'(r_symbols_loaded))
                     && !r_symbols_overflow;
        store_room = r_symbols_loaded < LOADED_W'(MAX_SYMBOLS);
    end

    // result of the word being taken
    always_comb begin
        n_pend_done   = 1'b0;
        n_pend_status = ST_OK;
        if (t_op'(i_op) == OP_DECODE) begin
            if (!r_table_valid) begin
                n_pend_status = ST_BAD_TABLE;
            end else if (dec_hit) begin
                n_pend_done = 1'b1;
            end else if (!dec_extend) begin
                n_pend_status = ST_NO_CODE;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_level_counts[i] <= '0;
            end
            r_symbols_loaded   <= '0;
            r_symbols_overflow <= 1'b0;
            r_table_valid      <= 1'b0;
            r_deepest_length   <= '0;
            r_last_code        <= '0;
            r_prefix_code      <= '0;
            r_prefix_length    <= '0;
            r_build_idx        <= '0;
            r_build_code       <= '0;
            r_build_offset     <= '0;
            r_build_good       <= 1'b0;
            r_out_valid        <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                case (t_op'(i_op))
                    OP_START: begin
                        for (int i = 0; i < LEVELS; i++) begin
                            r_level_counts[i] <= '0;
                        end
                        r_symbols_loaded   <= '0;
                        r_symbols_overflow <= 1'b0;
                        r_table_valid      <= 1'b0;
                        r_prefix_code      <= '0;
                        r_prefix_length    <= '0;
                    end
                    OP_SET_COUNT: begin
                        if ({1'b0, i_level} < LEN_W'(MAX_CODE_LENGTH)) begin
                            r_level_counts[i_level] <= i_code_count;
                            r_table_valid           <= 1'b0;
                            r_prefix_code           <= '0;
                            r_prefix_length         <= '0;
                        end
                    end
                    OP_APPEND: begin
                        if (store_room) begin
                            r_symbols_loaded <= r_symbols_loaded + LOADED_W'(1);
                        end else begin
                            r_symbols_overflow <= 1'b1;
                        end
                        r_table_valid   <= 1'b0;
                        r_prefix_code   <= '0;
                        r_prefix_length <= '0;
                    end
                    OP_FINISH: begin
                        r_table_valid    <= 1'b0;
                        r_prefix_code    <= '0;
                        r_prefix_length  <= '0;
                        r_deepest_length <= '0;
                        r_last_code      <= '0;
                        r_build_idx      <= '0;
                        r_build_code     <= '0;
                        r_build_offset   <= '0;
                        r_build_good     <= 1'b1;
                    end
                    OP_DECODE: begin
                        if (r_table_valid && !dec_hit && dec_extend) begin
                            r_prefix_code   <= dec_code;
                            r_prefix_length <= dec_len;
                        end else begin
                            r_prefix_code   <= '0;
                            r_prefix_length <= '0;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.build_step) begin
                if (rd_count != '0) begin
                    r_deepest_length <= b_len;
                    r_last_code      <= b_sum[CODE_W-1:0] - CODE_W'(1);
                end
                r_build_idx    <= r_build_idx + LEVEL_W'(1);
                r_build_code   <= b_next;
                r_build_offset <= b_off_next;
                r_build_good   <= b_good;
                if (o_stat.build_last) begin
                    r_table_valid <= b_final;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // symbol store, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && (t_op'(i_op) == OP_APPEND) && store_room) begin
            mem_store[r_symbols_loaded[ADDR_W-1:0]] <= i_symbol_in;
        end
        if (i_cmd.take && (t_op'(i_op) == OP_DECODE)) begin
            r_rd_data <= mem_store[dec_addr];
        end
    end

    // built table and result words
    always_ff @(posedge i_clk) begin
        if (i_cmd.build_step) begin
            r_first_codes[r_build_idx]    <= r_build_code[FIRST_W-1:0];
            r_symbol_offsets[r_build_idx] <= r_build_offset[OFFSET_W-1:0];
            if (o_stat.build_last) begin
                r_pend_status <= b_final ? ST_OK : ST_BAD_TABLE;
            end
        end else if (i_cmd.take) begin
            r_pend_done   <= n_pend_done;
            r_pend_status <= n_pend_status;
        end
        if (i_cmd.load_out) begin
            r_out_sym    <= r_pend_done ? r_rd_data : '0;
            r_out_done   <= r_pend_done;
            r_out_status <= r_pend_status;
        end
    end

    assign o_stat.is_finish  = t_op'(i_op) == OP_FINISH;
    assign o_stat.build_last = r_build_idx == LEVEL_W'(LEVELS - 1);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_symbol_out  = r_out_sym;
    assign o_symbol_done = r_out_done;
    assign o_status      = r_out_status;

    a_prefix_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prefix_length != '0 |-> r_table_valid && (r_prefix_length < r_deepest_length))
        else $error("prefix deeper than the table");

    a_loaded_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_symbols_loaded <= LOADED_W'(MAX_SYMBOLS))
        else $error("symbol count past store size");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take && o_stat.is_finish |=> !r_table_valid && (r_prefix_length == '0))
        else $error("table valid during build");

endmodule

>>> rtl/core/canonical_huffman_bit_decoder.sv
// top level of the canonical huffman bit decoder
// canonical (jpeg-style) huffman decoder with a table loaded word by word:
// start clears the counts, set level count and append symbol fill the table,
// finish builds the canonical first codes and flags a bad table, and each
// decode word shifts one stream bit into the prefix and returns a symbol,
// a no-code error, a table error, or no symbol while the prefix grows.
// every input word gives one result word. rate: start, set level count,
// append symbol and decode words are taken one per cycle as long as
// results are drained; a result, with its symbol store read, waits in the
// pending registers until the output register is free. a finish word is
// accepted, then the build adder walks the sixteen levels, taking no input.
// a single input word is still taken while a result waits at the output.
module canonical_huffman_bit_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    chbd_in_if.sink    i_item,
    chbd_out_if.source o_result
);
    import chbd_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer: accept, build walk, result hand-off
    chbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // table, build arithmetic, decode compare and output register
    chbd_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_op          (i_item.op),
        .i_level       (i_item.level),
        .i_code_count  (i_item.code_count),
        .i_symbol_in   (i_item.symbol_in),
        .i_bit_in      (i_item.bit_in),
        .o_out_valid   (o_result.valid),
        .i_out_ready   (o_result.ready),
        .o_symbol_out  (o_result.symbol_out),
        .o_symbol_done (o_result.symbol_done),
        .o_status      (o_result.status)
    );

endmodule

>>> dv/tb_top.sv
// self-checking testbench of the canonical huffman bit decoder
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import chbd_pkg::*;

    // run length and end-of-run timing
    localparam int RANDOM_WORDS = 760;      // least number of words sent by the random part
    localparam int CYCLE_LIMIT  = 1000000;  // watchdog, far beyond the slowest legal run
    localparam int TAIL_CYCLES  = 40;       // a finish walk plus output latency, with margin
    localparam int MAX_REPORTS  = 10;

    // one input word as the sender drives it; op stays a raw vector so that
    // the unused codes can be sent too
    typedef struct {
        logic [OP_W-1:0]    op;
        logic [LEVEL_W-1:0] level;
        logic [COUNT_W-1:0] code_count;
        logic [SYM_W-1:0]   symbol_in;
        logic               bit_in;
    } t_in_word;

    // one result word as the decoder should return it
    typedef struct {
        logic [SYM_W-1:0] symbol_out;
        logic             symbol_done;
        t_status          status;
    } t_result_word;

    logic clk;
    logic rst_n;

    chbd_in_if  item_if ();
    chbd_out_if result_if ();

    canonical_huffman_bit_decoder u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    // ------------------------------------------------------------------
    // decoder state as the testbench tracks it
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0]  cnt_per_len   [LEVELS];      // codes of each length
    logic [FIRST_W-1:0]  first_code_of [LEVELS];      // canonical first code per length
    logic [OFFSET_W-1:0] base_index_of [LEVELS];      // store index of that first code
    logic [SYM_W-1:0]    sym_table     [STORE_DEPTH];
    logic [LOADED_W-1:0] n_appended;
    bit                  append_overflow;
    bit                  table_ok;
    logic [CODE_W-1:0]   cur_code;                    // prefix bits taken so far
    logic [LEN_W-1:0]    cur_len;
    logic [LEN_W-1:0]    longest_len;                 // deepest length that has codes
    logic [CODE_W-1:0]   longest_last;                // last code of the deepest length

    t_result_word pending_results[$];  // expected results, oldest first
    int unsigned  n_words;             // input words accepted
    int unsigned  n_results;           // result words taken
    int unsigned  n_errors;
    bit           gaps_on = 1'b1;      // idling on both sides; off gives back-to-back stretches

    initial begin
        foreach (cnt_per_len[i]) begin
            cnt_per_len[i]   = '0;
            first_code_of[i] = '0;
            base_index_of[i] = '0;
        end
        foreach (sym_table[i]) sym_table[i] = '0;
        n_appended      = '0;
        append_overflow = 1'b0;
        table_ok        = 1'b0;
        cur_code        = '0;
        cur_len         = '0;
        longest_len     = '0;
        longest_last    = '0;
    end

    function automatic void go_root();
        cur_code = '0;
        cur_len  = '0;
    endfunction

    // canonical build: codes of one length are consecutive, and the next
    // length starts at (last + 1) * 2; the running code is held below 2^18
    // once it has already overflowed
    function automatic bit rebuild_table();
        int unsigned code;
        int unsigned offset;
        int unsigned n;
        bit          good;
        code         = 0;
        offset       = 0;
        good         = 1'b1;
        longest_len  = '0;
        longest_last = '0;
        for (int len = 1; len <= LEVELS; len++) begin
            n = cnt_per_len[len-1];
            first_code_of[len-1] = code[FIRST_W-1:0];
            base_index_of[len-1] = offset[OFFSET_W-1:0];
            if (n != 0) begin
                longest_len  = LEN_W'(len);
                longest_last = CODE_W'(code + n - 1);
            end
            code   += n;
            offset += n;
            if (code > (32'd1 << len)) good = 1'b0;  // level overflows its code space
            code = code << 1;
            if (code > 32'h3FFFF) code = 32'h3FFFF;
        end
        // symbol count must match the counts, and no append may have been dropped
        if (offset != n_appended || append_overflow) good = 1'b0;
        return good;
    endfunction

    // expected result of one accepted word; updates the tracked state
    function automatic t_result_word decoder_response(input t_in_word w);
        t_result_word r;
        int unsigned  len;
        int unsigned  code;
        int unsigned  idx;
        int unsigned  diff;
        r.symbol_out  = '0;
        r.symbol_done = 1'b0;
        r.status      = ST_OK;
        case (w.op)
            OP_START: begin
                // the store keeps its old symbols; counts, append count and table go
                foreach (cnt_per_len[i]) cnt_per_len[i] = '0;
                n_appended      = '0;
                append_overflow = 1'b0;
                table_ok        = 1'b0;
                go_root();
            end
            OP_SET_COUNT: begin
                // the 4-bit level always names a legal length
                cnt_per_len[w.level] = w.code_count;
                table_ok = 1'b0;
                go_root();
            end
            OP_APPEND: begin
                if (n_appended < MAX_SYMBOLS) begin
                    sym_table[n_appended[ADDR_W-1:0]] = w.symbol_in;
                    n_appended++;
                end else begin
                    append_overflow = 1'b1;
                end
                table_ok = 1'b0;
                go_root();
            end
            OP_FINISH: begin
                table_ok = rebuild_table();
                if (!table_ok) r.status = ST_BAD_TABLE;
                go_root();
            end
            OP_DECODE: begin
                if (!table_ok) begin
                    r.status = ST_BAD_TABLE;
                    go_root();
                end else begin
                    len  = cur_len + 1;
                    code = ((32'(cur_code) << 1) | 32'(w.bit_in)) & 32'hFFFF;
                    idx  = (len - 1) & 15;
                    diff = code - first_code_of[idx];
                    if (len <= LEVELS && code >= first_code_of[idx] &&
                        diff < cnt_per_len[idx]) begin
                        // complete code of this length
                        r.symbol_out  = sym_table[ADDR_W'(base_index_of[idx] + diff)];
                        r.symbol_done = 1'b1;
                        go_root();
                    end else if (len < longest_len && len < LEVELS &&
                                 code <= (32'(longest_last) >> (longest_len - len))) begin
                        // prefix can still grow into a code
                        cur_code = code[CODE_W-1:0];
                        cur_len  = LEN_W'(len);
                    end else begin
                        r.status = ST_NO_CODE;
                        go_root();
                    end
                end
            end
            default: ;  // unused op codes leave everything alone
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // clock, watchdog, idling
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results still expected",
                 cycles, pending_results.size());
        $display("DONE: errors detected");
        $finish;
    end

    // gap length: mostly none, often short, now and then long
    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // result side: ready with random stalls, and the checker
    // ------------------------------------------------------------------
    initial begin : result_ready
        int stall_left;
        stall_left = 0;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall_left == 0) stall_left = pick_gap();
            if (stall_left > 0) begin
                result_if.ready <= 1'b0;
                stall_left--;
            end else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    function automatic void log_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS) $display("error: %s", msg);
    endfunction

    // values are sampled at the clock edge, before any update of that edge
    initial begin : result_checker
        t_result_word exp;
        forever begin
            @(posedge clk);
            if (rst_n && result_if.valid && result_if.ready) begin
                if (pending_results.size() == 0) begin
                    log_error($sformatf("result word %0d with none expected: sym %02h done %0b status %0d",
                                        n_results, result_if.symbol_out,
                                        result_if.symbol_done, result_if.status));
                end else begin
                    exp = pending_results[0];
                    pending_results.delete(0);
                    if (result_if.symbol_out !== exp.symbol_out ||
                        result_if.symbol_done !== exp.symbol_done ||
                        result_if.status !== exp.status) begin
                        log_error($sformatf({"result word %0d: expected sym %02h done %0b status %0d,",
                                             " got sym %02h done %0b status %0d"},
                                            n_results, exp.symbol_out, exp.symbol_done,
                                            exp.status, result_if.symbol_out,
                                            result_if.symbol_done, result_if.status));
                    end
                end
                n_results++;
            end
        end
    end

    // ------------------------------------------------------------------
    // word sender and its wrappers
    // ------------------------------------------------------------------

    // drives one word until it is taken, records its expected result, then
    // maybe idles; valid is lowered only when a gap follows, so a steady
    // valid never sees two updates in one step
    task automatic send_word(input t_in_word w);
        int gap;
        item_if.valid      <= 1'b1;
        item_if.op         <= w.op;
        item_if.level      <= w.level;
        item_if.code_count <= w.code_count;
        item_if.symbol_in  <= w.symbol_in;
        item_if.bit_in     <= w.bit_in;
        @(posedge clk);
        while (!item_if.ready) @(posedge clk);
        pending_results.push_back(decoder_response(w));
        n_words++;
        gap = pick_gap();
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // fields that the op does not use carry random values
    function automatic t_in_word junk_word(input logic [OP_W-1:0] op);
        t_in_word w;
        w.op         = op;
        w.level      = LEVEL_W'($urandom);
        w.code_count = COUNT_W'($urandom);
        w.symbol_in  = SYM_W'($urandom);
        w.bit_in     = 1'($urandom);
        return w;
    endfunction

    task automatic put_start();
        send_word(junk_word(OP_START));
    endtask

    task automatic put_count(input int lvl, input int n);
        t_in_word w;
        w = junk_word(OP_SET_COUNT);
        w.level      = LEVEL_W'(lvl);
        w.code_count = COUNT_W'(n);
        send_word(w);
    endtask

    task automatic put_symbol(input int s);
        t_in_word w;
        w = junk_word(OP_APPEND);
        w.symbol_in = SYM_W'(s);
        send_word(w);
    endtask

    task automatic put_finish();
        send_word(junk_word(OP_FINISH));
    endtask

    task automatic put_bit(input logic b);
        t_in_word w;
        w = junk_word(OP_DECODE);
        w.bit_in = b;
        send_word(w);
    endtask

    // pressure point: hold the sender until every result is back
    task automatic wait_drain();
        item_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    // a stream of decode words: mostly whole codes of random symbols of the
    // current table, some loose bits, and a rare random word of any op
    task automatic decode_stream(input int n_items);
        int          r;
        int          k;
        int          len;
        int unsigned code;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                send_word(junk_word(OP_W'($urandom)));
            end else if (r < 14 || !table_ok || n_appended == 0) begin
                repeat ($urandom_range(1, 4)) put_bit(1'($urandom));
            end else begin
                // find the length and code of symbol k from the built table
                k    = $urandom_range(0, n_appended - 1);
                len  = 0;
                code = 0;
                for (int l = 1; l <= LEVELS; l++) begin
                    if (len == 0 && k >= base_index_of[l-1] &&
                        k < base_index_of[l-1] + cnt_per_len[l-1]) begin
                        len  = l;
                        code = first_code_of[l-1] + (k - base_index_of[l-1]);
                    end
                end
                // most significant bit first
                for (int b = len - 1; b >= 0; b--) put_bit(code[b]);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // no table yet: table errors, unused ops, and the empty table
    task automatic test_no_table();
        put_bit(1'b0);
        put_bit(1'b1);
        for (int k = int'(OP_DECODE) + 1; k < (1 << OP_W); k++)
            send_word(junk_word(OP_W'(k)));
        put_start();
        put_finish();   // no codes at all is a legal table
        put_bit(1'b1);  // so every bit is a dead prefix
    endtask

    // one-bit codes with extreme symbols, then count mismatch and overflow
    task automatic test_small_tables();
        put_start();
        put_count(0, 2);
        put_symbol(0);
        put_symbol(255);
        put_finish();
        put_bit(1'b0);
        put_bit(1'b1);
        // editing a built table drops it until the next finish
        put_count(LEVELS - 1, 255);
        put_bit(1'b0);
        put_finish();   // counts no longer match the symbols
        // three one-bit codes do not fit
        put_start();
        put_count(0, 3);
        repeat (3) put_symbol($urandom_range(0, 255));
        put_finish();
        put_bit(1'b1);
    endtask

    // full store: 255 eight-bit codes and one sixteen-bit code, then one
    // append too many
    task automatic test_store_full();
        put_start();
        put_count(7, 255);
        put_count(LEVELS - 1, 1);
        put_symbol(0);
        for (int i = 1; i < MAX_SYMBOLS - 1; i++) put_symbol($urandom_range(0, 255));
        put_symbol(255);
        put_finish();
        repeat (8) put_bit(1'b1);   // the sixteen-bit code 0xff00
        repeat (8) put_bit(1'b0);
        repeat (16) put_bit(1'b1);  // runs past the last code
        repeat (8) put_bit(1'b0);   // the first zero completes the eight-bit code 0xfe
        decode_stream(12);
        put_symbol($urandom_range(0, 255));  // dropped, the next finish fails
        put_finish();
        put_bit(1'b0);
    endtask

    // random tables, mostly well formed, each followed by a decode stream
    task automatic test_random_tables();
        int cnt[LEVELS];
        int order[LEVELS];
        int first_word;
        int left;
        int room;
        int deepest;
        int lim;
        int total;
        int extra;
        int j;
        int tmp;
        bit broken;
        first_word = n_words;
        while (n_words - first_word < RANDOM_WORDS) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            broken  = ($urandom_range(0, 99) < 15);
            // lengths down to a random depth; every level but the deepest
            // leaves room below it, so the table is never overfull
            left    = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 120)
                                                   : $urandom_range(1, 20);
            deepest = $urandom_range(1, LEVELS);
            room    = 1;
            total   = 0;
            for (int l = 1; l <= LEVELS; l++) begin
                cnt[l-1] = 0;
                if (l <= deepest) begin
                    room = room * 2;
                    lim  = left;
                    if (lim > room) lim = room;
                    if (lim > 255) lim = 255;
                    if (l < deepest && lim == room) lim = room - 1;
                    cnt[l-1] = (l == deepest) ? lim : $urandom_range(0, lim);
                    room  -= cnt[l-1];
                    left  -= cnt[l-1];
                    total += cnt[l-1];
                end
            end
            extra = 0;
            if (broken) begin
                case ($urandom_range(0, 2))
                    0: extra = (total > 0 && $urandom_range(0, 1) == 1) ? -1 : 1;
                    1: begin
                        j = $urandom_range(0, 6);
                        cnt[j] = (1 << (j + 1)) + 1;   // one code too many for the level
                    end
                    default: cnt[$urandom_range(0, LEVELS - 1)] = $urandom_range(0, 255);
                endcase
                total = 0;
                foreach (cnt[i]) total += cnt[i];
            end
            // counts in random order, symbols in code order
            foreach (order[i]) order[i] = i;
            for (int i = LEVELS - 1; i > 0; i--) begin
                j        = $urandom_range(0, i);
                tmp      = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            put_start();
            foreach (order[i]) begin
                if (cnt[order[i]] != 0 || $urandom_range(0, 7) == 0)
                    put_count(order[i], cnt[order[i]]);
            end
            for (int i = 0; i < total + extra; i++) put_symbol($urandom_range(0, 255));
            put_finish();
            decode_stream($urandom_range(4, 30));
            if ($urandom_range(0, 9) == 0) wait_drain();
        end
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        rst_n              <= 1'b0;
        item_if.valid      <= 1'b0;
        item_if.op         <= '0;
        item_if.level      <= '0;
        item_if.code_count <= '0;
        item_if.symbol_in  <= '0;
        item_if.bit_in     <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_no_table();
        test_small_tables();
        wait_drain();
        test_store_full();
        wait_drain();
        test_random_tables();

        // let the last results come back, then a little quiet time for
        // anything that should not be there
        item_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> canonical_huffman_bit_decoder.f
rtl/core/chbd_pkg.sv
rtl/core/chbd_in_if.sv
rtl/core/chbd_out_if.sv
rtl/core/chbd_ctrl.sv
rtl/core/chbd_dp.sv
rtl/core/canonical_huffman_bit_decoder.sv
dv/tb_top.sv
